### rtl/oip_pkg.sv
// ----------------------------------------------------------------------------
// oip_pkg
// Shared types and constants for the off-screen indicator placement block.
// ----------------------------------------------------------------------------
package oip_pkg;

   // classified beat handed from the front end to the back end
   typedef struct packed {
      logic               shown;
      logic [30:0]        ax;
      logic [30:0]        ay;
      logic [15:0]        angle;
      logic [15:0]        zoom;
      logic signed [31:0] vis_x;
      logic signed [31:0] vis_y;
      logic [30:0]        vis_w;
      logic [30:0]        vis_h;
   } oip_item_type;

   localparam int               SQRT_STEPS   = 32;
   localparam int               ATAN_COUNT   = 24;
   localparam logic [15:0]      MARGIN_RESET = 16'd2560;
   localparam logic signed [33:0] CORDIC_X0  = 34'sd652032874;

   // arctangent of 2^-i in Q0.32 turns
   function automatic logic [31:0] atan_turns(input int idx);
      logic [31:0] val;
      unique case (idx)
         0:       val = 32'd536870912;
         1:       val = 32'd316933406;
         2:       val = 32'd167458907;
         3:       val = 32'd85004756;
         4:       val = 32'd42667331;
         5:       val = 32'd21354465;
         6:       val = 32'd10679838;
         7:       val = 32'd5340245;
         8:       val = 32'd2670163;
         9:       val = 32'd1335087;
         10:      val = 32'd667544;
         11:      val = 32'd333772;
         12:      val = 32'd166886;
         13:      val = 32'd83443;
         14:      val = 32'd41722;
         15:      val = 32'd20861;
         16:      val = 32'd10430;
         17:      val = 32'd5215;
         18:      val = 32'd2608;
         19:      val = 32'd1304;
         20:      val = 32'd652;
         21:      val = 32'd326;
         22:      val = 32'd163;
         23:      val = 32'd81;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

### rtl/oip_front.sv
// ----------------------------------------------------------------------------
// oip_front
// Accepts a request, tests the point against the camera rectangle and
// forms the saturated offsets from the camera centre.
// ----------------------------------------------------------------------------
module oip_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   input  logic signed [31:0]   req_target_x,
   input  logic signed [31:0]   req_target_y,
   input  logic [15:0]          req_angle_turns,
   input  logic signed [31:0]   req_cam_origin_x,
   input  logic signed [31:0]   req_cam_origin_y,
   input  logic [30:0]          req_cam_width,
   input  logic [30:0]          req_cam_height,
   input  logic signed [31:0]   req_vis_origin_x,
   input  logic signed [31:0]   req_vis_origin_y,
   input  logic [30:0]          req_vis_width,
   input  logic [30:0]          req_vis_height,
   input  logic [15:0]          req_zoom,
   output logic                 item_valid,
   output oip_pkg::oip_item_type item_out
);
   import oip_pkg::*;

   logic signed [33:0] tx_e, ty_e, cx_e, cy_e, cw_e, ch_e, cwh_e, chh_e;
   logic signed [33:0] dx, dy;
   logic [33:0]        mx, my;
   logic               in_cam;
   logic               valid_ff, valid_in;
   oip_item_type       item_ff, item_in;

   assign tx_e  = 34'(req_target_x);
   assign ty_e  = 34'(req_target_y);
   assign cx_e  = 34'(req_cam_origin_x);
   assign cy_e  = 34'(req_cam_origin_y);
   assign cw_e  = $signed({3'b000, req_cam_width});
   assign ch_e  = $signed({3'b000, req_cam_height});
   assign cwh_e = $signed({4'b0000, req_cam_width[30:1]});
   assign chh_e = $signed({4'b0000, req_cam_height[30:1]});

   assign in_cam = (tx_e >= cx_e) && (tx_e <= cx_e + cw_e) &&
                   (ty_e >= cy_e) && (ty_e <= cy_e + ch_e);

   assign dx = tx_e - (cx_e + cwh_e);
   assign dy = ty_e - (cy_e + chh_e);
   assign mx = dx[33] ? 34'(-dx) : 34'(dx);
   assign my = dy[33] ? 34'(-dy) : 34'(dy);

   always_comb begin
      item_in.shown = ~in_cam;
      item_in.ax    = (mx > 34'h7FFFFFFF) ? 31'h7FFFFFFF : mx[30:0];
      item_in.ay    = (my > 34'h7FFFFFFF) ? 31'h7FFFFFFF : my[30:0];
      item_in.angle = req_angle_turns;
      item_in.zoom  = req_zoom;
      item_in.vis_x = req_vis_origin_x;
      item_in.vis_y = req_vis_origin_y;
      item_in.vis_w = req_vis_width;
      item_in.vis_h = req_vis_height;
      valid_in      = req_fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_fire) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item_out   = item_ff;

endmodule

### rtl/oip_queue.sv
// ----------------------------------------------------------------------------
// oip_queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module oip_queue #(
   parameter int DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  oip_pkg::oip_item_type        push_item,
   input  logic                         pop,
   output oip_pkg::oip_item_type        head_item,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);
   import oip_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   oip_item_type  entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign do_pop  = pop && (count_ff != '0);
   assign do_push = push && (count_ff != CW'(DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item = entry_ff[rd_ptr_ff];
   assign empty     = (count_ff == '0);
   assign count     = count_ff;

endmodule

### rtl/oip_back.sv
// ----------------------------------------------------------------------------
// oip_back
// Distance, zoom scaling, CORDIC direction and clamping, fully pipelined.
// ----------------------------------------------------------------------------
module oip_back #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  oip_pkg::oip_item_type in_item,
   input  logic [15:0]           edge_margin,
   output logic                  out_valid,
   output logic                  out_shown,
   output logic signed [31:0]    out_x,
   output logic signed [31:0]    out_y
);
   import oip_pkg::*;

   typedef struct packed {
      logic               shown;
      logic [15:0]        zoom;
      logic signed [31:0] vis_x;
      logic signed [31:0] vis_y;
      logic [30:0]        vis_w;
      logic [30:0]        vis_h;
   } side_type;

   side_type in_side;

   assign in_side.shown = in_item.shown;
   assign in_side.zoom  = in_item.zoom;
   assign in_side.vis_x = in_item.vis_x;
   assign in_side.vis_y = in_item.vis_y;
   assign in_side.vis_w = in_item.vis_w;
   assign in_side.vis_h = in_item.vis_h;

   // squares
   logic        sq_valid_ff;
   side_type    sq_side_ff;
   logic [15:0] sq_angle_ff;
   logic [61:0] sqx_ff, sqy_ff;

   // sum
   logic        sum_valid_ff;
   side_type    sum_side_ff;
   logic [15:0] sum_angle_ff;
   logic [62:0] sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff  <= in_valid;
         sum_valid_ff <= sq_valid_ff;
      end
      sq_side_ff   <= in_side;
      sq_angle_ff  <= in_item.angle;
      sqx_ff       <= 62'(in_item.ax) * 62'(in_item.ax);
      sqy_ff       <= 62'(in_item.ay) * 62'(in_item.ay);
      sum_side_ff  <= sq_side_ff;
      sum_angle_ff <= sq_angle_ff;
      sum_ff       <= 63'(sqx_ff) + 63'(sqy_ff);
   end

   // square root digit stages with CORDIC rotations alongside
   logic               st_valid_ff [SQRT_STEPS];
   side_type           st_side_ff  [SQRT_STEPS];
   logic [1:0]         st_quad_ff  [SQRT_STEPS];
   logic [63:0]        st_rem_ff   [SQRT_STEPS];
   logic [63:0]        st_res_ff   [SQRT_STEPS];
   logic signed [33:0] st_x_ff     [SQRT_STEPS];
   logic signed [33:0] st_y_ff     [SQRT_STEPS];
   logic signed [33:0] st_z_ff     [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (2 * (SQRT_STEPS - 1 - k));
      logic               valid_i;
      side_type           side_i;
      logic [1:0]         quad_i;
      logic [63:0]        rem_i, res_i, trial, rem_n, res_n;
      logic signed [33:0] x_i, y_i, z_i, x_n, y_n, z_n, atan_v;

      if (k == 0) begin : g_first
         assign valid_i = sum_valid_ff;
         assign side_i  = sum_side_ff;
         assign quad_i  = sum_angle_ff[15:14];
         assign rem_i   = 64'(sum_ff);
         assign res_i   = '0;
         assign x_i     = CORDIC_X0;
         assign y_i     = '0;
         assign z_i     = $signed({4'b0000, sum_angle_ff[13:0], 16'h0000});
      end else begin : g_next
         assign valid_i = st_valid_ff[k-1];
         assign side_i  = st_side_ff[k-1];
         assign quad_i  = st_quad_ff[k-1];
         assign rem_i   = st_rem_ff[k-1];
         assign res_i   = st_res_ff[k-1];
         assign x_i     = st_x_ff[k-1];
         assign y_i     = st_y_ff[k-1];
         assign z_i     = st_z_ff[k-1];
      end

      assign atan_v = $signed({2'b00, atan_turns(k)});
      assign trial  = res_i + BIT;

      always_comb begin
         if (rem_i >= trial) begin
            rem_n = rem_i - trial;
            res_n = (res_i >> 1) + BIT;
         end else begin
            rem_n = rem_i;
            res_n = res_i >> 1;
         end
         x_n = x_i;
         y_n = y_i;
         z_n = z_i;
         if (k < CORDIC_STEPS) begin
            if (!z_i[33]) begin
               x_n = x_i - (y_i >>> k);
               y_n = y_i + (x_i >>> k);
               z_n = z_i - atan_v;
            end else begin
               x_n = x_i + (y_i >>> k);
               y_n = y_i - (x_i >>> k);
               z_n = z_i + atan_v;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_valid_ff[k] <= 1'b0;
         end else begin
            st_valid_ff[k] <= valid_i;
         end
         st_side_ff[k] <= side_i;
         st_quad_ff[k] <= quad_i;
         st_rem_ff[k]  <= rem_n;
         st_res_ff[k]  <= res_n;
         st_x_ff[k]    <= x_n;
         st_y_ff[k]    <= y_n;
         st_z_ff[k]    <= z_n;
      end
   end

   // zoom scaling and quadrant fold
   logic               zm_valid_ff;
   side_type           zm_side_ff;
   logic [47:0]        zm_prod_ff;
   logic signed [33:0] zm_c_ff, zm_s_ff, cos_in, sin_in;
   logic signed [33:0] fx, fy;

   assign fx = st_x_ff[SQRT_STEPS-1];
   assign fy = st_y_ff[SQRT_STEPS-1];

   always_comb begin
      unique case (st_quad_ff[SQRT_STEPS-1])
         2'd0: begin
            cos_in = fx;
            sin_in = fy;
         end
         2'd1: begin
            cos_in = -fy;
            sin_in = fx;
         end
         2'd2: begin
            cos_in = -fx;
            sin_in = -fy;
         end
         default: begin
            cos_in = fy;
            sin_in = -fx;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zm_valid_ff <= 1'b0;
      end else begin
         zm_valid_ff <= st_valid_ff[SQRT_STEPS-1];
      end
      zm_side_ff <= st_side_ff[SQRT_STEPS-1];
      zm_prod_ff <= 48'(st_res_ff[SQRT_STEPS-1][31:0]) *
                    48'(st_side_ff[SQRT_STEPS-1].zoom);
      zm_c_ff    <= cos_in;
      zm_s_ff    <= sin_in;
   end

   // trig products
   logic        tm_valid_ff;
   side_type    tm_side_ff;
   logic [65:0] tm_px_ff, tm_py_ff;
   logic        tm_nx_ff, tm_ny_ff;
   logic [39:0] d_full;
   logic [31:0] d_sat;
   logic [33:0] cmag, smag;

   assign d_full = zm_prod_ff[47:8];
   assign d_sat  = (d_full > 40'hFFFFFFFF) ? 32'hFFFFFFFF : d_full[31:0];
   assign cmag   = zm_c_ff[33] ? 34'(-zm_c_ff) : 34'(zm_c_ff);
   assign smag   = zm_s_ff[33] ? 34'(-zm_s_ff) : 34'(zm_s_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         tm_valid_ff <= 1'b0;
      end else begin
         tm_valid_ff <= zm_valid_ff;
      end
      tm_side_ff <= zm_side_ff;
      tm_px_ff   <= 66'(d_sat) * 66'(cmag);
      tm_py_ff   <= 66'(d_sat) * 66'(smag);
      tm_nx_ff   <= zm_c_ff[33];
      tm_ny_ff   <= zm_s_ff[33];
   end

   // round, sign and add to the visible centre
   logic               ad_valid_ff;
   side_type           ad_side_ff;
   logic signed [39:0] ad_px_ff, ad_py_ff;
   logic [35:0]        mx, my;
   logic signed [39:0] offx, offy, cenx, ceny;

   assign mx   = 36'((tm_px_ff + 66'd536870912) >> 30);
   assign my   = 36'((tm_py_ff + 66'd536870912) >> 30);
   assign offx = tm_nx_ff ? -$signed({4'b0000, mx}) : $signed({4'b0000, mx});
   assign offy = tm_ny_ff ? -$signed({4'b0000, my}) : $signed({4'b0000, my});
   assign cenx = 40'(tm_side_ff.vis_x) + $signed({10'b0, tm_side_ff.vis_w[30:1]});
   assign ceny = 40'(tm_side_ff.vis_y) + $signed({10'b0, tm_side_ff.vis_h[30:1]});

   always_ff @(posedge clock) begin
      if (reset) begin
         ad_valid_ff <= 1'b0;
      end else begin
         ad_valid_ff <= tm_valid_ff;
      end
      ad_side_ff <= tm_side_ff;
      ad_px_ff   <= cenx + offx;
      ad_py_ff   <= ceny + offy;
   end

   // clamp to the inset rectangle; lower bound wins
   logic signed [39:0] marg, lox, hix, loy, hiy, cx1, cy1, cx2, cy2;
   logic signed [31:0] satx, saty;
   logic               out_valid_ff, out_shown_ff;
   logic signed [31:0] out_x_ff, out_y_ff;

   assign marg = $signed({24'b0, edge_margin});
   assign lox  = 40'(ad_side_ff.vis_x) + marg;
   assign loy  = 40'(ad_side_ff.vis_y) + marg;
   assign hix  = 40'(ad_side_ff.vis_x) + $signed({9'b0, ad_side_ff.vis_w}) - marg;
   assign hiy  = 40'(ad_side_ff.vis_y) + $signed({9'b0, ad_side_ff.vis_h}) - marg;
   assign cx1  = (ad_px_ff > hix) ? hix : ad_px_ff;
   assign cy1  = (ad_py_ff > hiy) ? hiy : ad_py_ff;
   assign cx2  = (cx1 < lox) ? lox : cx1;
   assign cy2  = (cy1 < loy) ? loy : cy1;

   always_comb begin
      if (cx2 > 40'sd2147483647) begin
         satx = 32'sh7FFFFFFF;
      end else if (cx2 < -40'sd2147483648) begin
         satx = 32'sh80000000;
      end else begin
         satx = cx2[31:0];
      end
      if (cy2 > 40'sd2147483647) begin
         saty = 32'sh7FFFFFFF;
      end else if (cy2 < -40'sd2147483648) begin
         saty = 32'sh80000000;
      end else begin
         saty = cy2[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= ad_valid_ff;
      end
      out_shown_ff <= ad_side_ff.shown;
      // hidden indicators report zero positions
      out_x_ff     <= ad_side_ff.shown ? satx : '0;
      out_y_ff     <= ad_side_ff.shown ? saty : '0;
   end

   assign out_valid = out_valid_ff;
   assign out_shown = out_shown_ff;
   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;

endmodule

### rtl/offscreen_indicator_placement.sv
// Throughput: one beat per cycle; the 32-stage square root pipeline with the CORDIC
// rotations beside it sets the depth, and every stage takes a new beat each cycle.
// busy rises only when the front queue would overflow, which a free-running back end
// never causes. Reset clears all valid bits and loads edge_margin with 10.0 (2560).
// ----------------------------------------------------------------------------
// offscreen_indicator_placement
// Places an off-screen indicator along a direction, clamped to the view.
// ----------------------------------------------------------------------------
module offscreen_indicator_placement #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic [15:0]        req_angle_turns,
   input  logic signed [31:0] req_cam_origin_x,
   input  logic signed [31:0] req_cam_origin_y,
   input  logic [30:0]        req_cam_width,
   input  logic [30:0]        req_cam_height,
   input  logic signed [31:0] req_vis_origin_x,
   input  logic signed [31:0] req_vis_origin_y,
   input  logic [30:0]        req_vis_width,
   input  logic [30:0]        req_vis_height,
   input  logic [15:0]        req_zoom,
   input  logic               csr_write_en,
   input  logic [15:0]        csr_write_data,
   output logic               rsp_valid,
   output logic               rsp_shown,
   output logic signed [31:0] rsp_place_x,
   output logic signed [31:0] rsp_place_y
);
   import oip_pkg::*;

   localparam int QDEPTH = 2;
   localparam int QCW    = $clog2(QDEPTH+1);

   logic [15:0]   edge_margin_ff, edge_margin_in;
   logic          req_fire;
   logic          fe_valid, q_empty;
   oip_item_type  fe_item, q_head;
   logic [QCW-1:0] q_count;

   assign edge_margin_in = csr_write_en ? csr_write_data : edge_margin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_margin_ff <= MARGIN_RESET;
      end else begin
         edge_margin_ff <= edge_margin_in;
      end
   end

   // hold off when the queue plus the beat in the front register would overflow
   assign busy     = ((QCW+1)'(q_count) + (QCW+1)'(fe_valid)) > (QCW+1)'(QDEPTH);
   assign req_fire = start && !busy;

   oip_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_fire         (req_fire),
      .req_target_x     (req_target_x),
      .req_target_y     (req_target_y),
      .req_angle_turns  (req_angle_turns),
      .req_cam_origin_x (req_cam_origin_x),
      .req_cam_origin_y (req_cam_origin_y),
      .req_cam_width    (req_cam_width),
      .req_cam_height   (req_cam_height),
      .req_vis_origin_x (req_vis_origin_x),
      .req_vis_origin_y (req_vis_origin_y),
      .req_vis_width    (req_vis_width),
      .req_vis_height   (req_vis_height),
      .req_zoom         (req_zoom),
      .item_valid       (fe_valid),
      .item_out         (fe_item)
   );

   oip_queue #(
      .DEPTH (QDEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fe_valid),
      .push_item (fe_item),
      .pop       (!q_empty),
      .head_item (q_head),
      .empty     (q_empty),
      .count     (q_count)
   );

   oip_back #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (!q_empty),
      .in_item     (q_head),
      .edge_margin (edge_margin_ff),
      .out_valid   (rsp_valid),
      .out_shown   (rsp_shown),
      .out_x       (rsp_place_x),
      .out_y       (rsp_place_y)
   );

endmodule
